/* rtl/core/rrtt_pkg.sv */
`timescale 1ns / 1ps
// Package for the round-robin task table: sizes, slot state codes, item types
// and the command/view structs between the sequencer and the slot status file.
// No dependencies.
package rrtt_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int ID_W    = 32;

    typedef logic [2:0] t_st;

    localparam t_st ST_UNUSED  = 3'd0;
    localparam t_st ST_READY   = 3'd1;
    localparam t_st ST_RUNNING = 3'd2;
    localparam t_st ST_BLOCKED = 3'd3;
    localparam t_st ST_STOPPED = 3'd4;
    localparam t_st ST_DEAD    = 3'd5;

    localparam logic [1:0] ACT_CREATE = 2'd0;
    localparam logic [1:0] ACT_SCHED  = 2'd1;
    localparam logic [1:0] ACT_SET    = 2'd2;
    localparam logic [1:0] ACT_EXIT   = 2'd3;

    localparam logic [1:0] NS_READY   = 2'd0;
    localparam logic [1:0] NS_BLOCKED = 2'd1;
    localparam logic [1:0] NS_STOPPED = 2'd2;
    localparam logic [1:0] NS_DEAD    = 2'd3;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_NO_FREE  = 2'd1;
    localparam logic [1:0] STS_NO_RUN   = 2'd2;
    localparam logic [1:0] STS_UNUSED   = 2'd3;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] slot_sel;
        logic [1:0] new_state;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot_out;
        logic [31:0] task_ident;
        logic        switched;
        logic [4:0]  live_count;
    } t_res;

    typedef struct packed {
        logic              a_we;
        logic [SLOT_W-1:0] a_addr;
        t_st               a_val;
        logic              b_we;
        logic [SLOT_W-1:0] b_addr;
        t_st               b_val;
        logic              lk_we;
        logic [SLOT_W-1:0] lk_addr;
        logic              lk_val;
    } t_st_cmd;

    typedef struct packed {
        t_st               st_cur;
        t_st               st_sel;
        t_st               st_walk;
        logic              find_ok;
        logic [SLOT_W-1:0] find_slot;
        logic              find_dead;
        logic              find_linked;
        logic [CNT_W-1:0]  live;
    } t_st_view;

    function automatic logic is_live(t_st s);
        return (s == ST_READY) || (s == ST_RUNNING) || (s == ST_BLOCKED) ||
               (s == ST_STOPPED);
    endfunction

    function automatic t_st map_state(logic [1:0] ns);
        t_st s;
        unique case (ns)
            NS_READY:   s = ST_READY;
            NS_BLOCKED: s = ST_BLOCKED;
            NS_STOPPED: s = ST_STOPPED;
            NS_DEAD:    s = ST_DEAD;
            default:    s = ST_DEAD;
        endcase
        return s;
    endfunction

endpackage

/* rtl/core/round_robin_task_table.sv */
`timescale 1ns / 1ps
// Top level of the round-robin task table: sequencer, ring link and task id
// memories, result register. Depends on rrtt_pkg, rrtt_ram and rrtt_stat.
//
// One item is processed at a time; a new item is taken once the previous one
// has reached the result register, which holds it until the consumer takes it.
// Schedule walks the ring from the current slot, reading the link memory one
// slot per cycle. Exit marks the current slot dead before a schedule. Create
// reuses the dead current slot directly, reports when no slot is free, else
// links a slot in, and first unlinks a dead slot from the ring when needed,
// since finding its predecessor walks the same link memory.
module round_robin_task_table_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    input  logic            i_item_valid,
    output logic            o_item_ready,
    input  rrtt_pkg::t_item i_item,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output rrtt_pkg::t_res  o_res
);
    import rrtt_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CFIND  = 4'd1;
    localparam logic [3:0] S_UCHK   = 4'd2;
    localparam logic [3:0] S_IRD    = 4'd3;
    localparam logic [3:0] S_IWAIT  = 4'd4;
    localparam logic [3:0] S_IW2    = 4'd5;
    localparam logic [3:0] S_EXIT   = 4'd6;
    localparam logic [3:0] S_SSTART = 4'd7;
    localparam logic [3:0] S_SWALK  = 4'd8;
    localparam logic [3:0] S_SET    = 4'd9;
    localparam logic [3:0] S_IDRD   = 4'd10;
    localparam logic [3:0] S_RES    = 4'd11;

    logic [3:0]        r_state, n_state;
    t_item             r_item;
    logic              r_en;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [ID_W-1:0]   r_idc, n_idc;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [ID_W-1:0]   r_idv, n_idv;
    logic              r_have, n_have;
    logic              r_sw, n_sw;
    logic [1:0]        r_status, n_status;
    logic [SLOT_W-1:0] r_p, n_p;
    logic [SLOT_W-1:0] r_k, n_k;
    logic [SLOT_W-1:0] r_lv, n_lv;
    logic [SLOT_W-1:0] r_laddr;
    logic              r_lvld;
    logic [SLOTS-1:0]  r_link_vld, n_link_vld;
    logic [SLOTS-1:0]  r_id_vld, n_id_vld;
    logic              r_ivld;
    logic              r_ovalid, n_ovalid;
    t_res              r_ores, n_ores;

    t_st_cmd           st_cmd;
    t_st_view          st_view;
    logic              lk_we;
    logic [SLOT_W-1:0] lk_waddr;
    logic [SLOT_W-1:0] lk_wdata;
    logic              lk_re;
    logic [SLOT_W-1:0] lk_raddr;
    logic [SLOT_W-1:0] lk_q;
    logic [SLOT_W-1:0] link_q;
    logic              id_we;
    logic              id_re;
    logic [ID_W-1:0]   id_q;
    logic              walk_hit;
    logic [SLOT_W-1:0] res_slot;
    logic [ID_W-1:0]   res_ident;

    rrtt_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_re    (lk_re),
        .i_raddr (lk_raddr),
        .o_rdata (lk_q)
    );

    rrtt_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_ident_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (st_view.find_slot),
        .i_wdata (r_idc),
        .i_re    (id_re),
        .i_raddr (r_cur),
        .o_rdata (id_q)
    );

    rrtt_stat u_stat (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (st_cmd),
        .i_cur_addr  (r_cur),
        .i_sel_addr  (SLOT_W'(r_item.slot_sel)),
        .i_walk_addr (link_q),
        .o_view      (st_view)
    );

    assign link_q       = r_lvld ? lk_q : r_laddr;
    assign walk_hit     = (st_view.st_walk == ST_READY) || (st_view.st_walk == ST_RUNNING);
    assign o_item_ready = (r_state == S_IDLE);
    assign o_res_valid  = r_ovalid;
    assign o_res        = r_ores;
    assign res_slot     = r_have ? r_slot : r_cur;
    assign res_ident    = r_have ? r_idv : (r_ivld ? id_q : '0);

    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_idc      = r_idc;
        n_slot     = r_slot;
        n_idv      = r_idv;
        n_have     = r_have;
        n_sw       = r_sw;
        n_status   = r_status;
        n_p        = r_p;
        n_k        = r_k;
        n_lv       = r_lv;
        n_link_vld = r_link_vld;
        n_id_vld   = r_id_vld;
        n_ovalid   = r_ovalid & ~i_res_ready;
        n_ores     = r_ores;
        st_cmd     = '0;
        lk_we      = 1'b0;
        lk_waddr   = '0;
        lk_wdata   = '0;
        lk_re      = 1'b0;
        lk_raddr   = '0;
        id_we      = 1'b0;
        id_re      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                n_have   = 1'b0;
                n_sw     = 1'b0;
                n_status = STS_OK;
                if (i_item_valid) begin
                    unique case (i_item.action)
                        ACT_CREATE: n_state = S_CFIND;
                        ACT_SCHED:  n_state = S_SSTART;
                        ACT_SET:    n_state = S_SET;
                        ACT_EXIT:   n_state = S_EXIT;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_CFIND: begin
                if (!st_view.find_ok) begin
                    n_status = STS_NO_FREE;
                    n_state  = S_IDRD;
                end else begin
                    st_cmd.a_we   = 1'b1;
                    st_cmd.a_addr = st_view.find_slot;
                    st_cmd.a_val  = ST_READY;
                    id_we         = 1'b1;
                    n_id_vld[st_view.find_slot] = 1'b1;
                    n_idv  = r_idc;
                    n_idc  = r_idc + 1'b1;
                    n_slot = st_view.find_slot;
                    n_have = 1'b1;
                    if (st_view.find_slot == r_cur) begin
                        n_state = S_RES;
                    end else if (st_view.find_dead && st_view.find_linked) begin
                        lk_re    = 1'b1;
                        lk_raddr = st_view.find_slot;
                        n_p      = st_view.find_slot;
                        n_k      = '0;
                        n_state  = S_UCHK;
                    end else begin
                        n_state = S_IRD;
                    end
                end
            end
            S_UCHK: begin
                if (r_k == '0) begin
                    n_lv = link_q;
                end
                if (link_q == r_slot || r_k == SLOT_W'(SLOTS - 1)) begin
                    if (link_q == r_slot && r_p != r_slot) begin
                        lk_we    = 1'b1;
                        lk_waddr = r_p;
                        lk_wdata = r_lv;
                        n_link_vld[r_p] = 1'b1;
                    end
                    n_link_vld[r_slot] = 1'b0;
                    st_cmd.lk_we   = 1'b1;
                    st_cmd.lk_addr = r_slot;
                    st_cmd.lk_val  = 1'b0;
                    n_state        = S_IRD;
                end else begin
                    lk_re    = 1'b1;
                    lk_raddr = link_q;
                    n_p      = link_q;
                    n_k      = r_k + 1'b1;
                end
            end
            S_IRD: begin
                lk_re    = 1'b1;
                lk_raddr = r_cur;
                n_state  = S_IWAIT;
            end
            S_IWAIT: begin
                lk_we    = 1'b1;
                lk_waddr = r_slot;
                lk_wdata = link_q;
                n_link_vld[r_slot] = 1'b1;
                n_state  = S_IW2;
            end
            S_IW2: begin
                lk_we    = 1'b1;
                lk_waddr = r_cur;
                lk_wdata = r_slot;
                n_link_vld[r_cur] = 1'b1;
                st_cmd.lk_we   = 1'b1;
                st_cmd.lk_addr = r_slot;
                st_cmd.lk_val  = 1'b1;
                n_state        = S_RES;
            end
            S_EXIT: begin
                st_cmd.a_we   = 1'b1;
                st_cmd.a_addr = r_cur;
                st_cmd.a_val  = ST_DEAD;
                n_state       = S_SSTART;
            end
            S_SSTART: begin
                if (!r_en) begin
                    n_state = S_IDRD;
                end else begin
                    lk_re    = 1'b1;
                    lk_raddr = r_cur;
                    n_k      = '0;
                    n_state  = S_SWALK;
                end
            end
            S_SWALK: begin
                if (walk_hit) begin
                    if (link_q != r_cur) begin
                        st_cmd.a_we   = (st_view.st_cur == ST_RUNNING);
                        st_cmd.a_addr = r_cur;
                        st_cmd.a_val  = ST_READY;
                        st_cmd.b_we   = 1'b1;
                        st_cmd.b_addr = link_q;
                        st_cmd.b_val  = ST_RUNNING;
                        n_cur         = link_q;
                        n_sw          = 1'b1;
                    end
                    n_state = S_IDRD;
                end else if (r_k == SLOT_W'(SLOTS - 1)) begin
                    n_status = STS_NO_RUN;
                    n_state  = S_IDRD;
                end else begin
                    lk_re    = 1'b1;
                    lk_raddr = link_q;
                    n_k      = r_k + 1'b1;
                end
            end
            S_SET: begin
                if (int'(r_item.slot_sel) >= SLOTS || st_view.st_sel == ST_UNUSED) begin
                    n_status = STS_UNUSED;
                end else begin
                    st_cmd.a_we   = 1'b1;
                    st_cmd.a_addr = SLOT_W'(r_item.slot_sel);
                    st_cmd.a_val  = map_state(r_item.new_state);
                end
                n_state = S_IDRD;
            end
            S_IDRD: begin
                id_re   = 1'b1;
                n_state = S_RES;
            end
            S_RES: begin
                if (!r_ovalid || i_res_ready) begin
                    n_ovalid          = 1'b1;
                    n_ores.status     = r_status;
                    n_ores.slot_out   = 4'(res_slot);
                    n_ores.task_ident = res_ident;
                    n_ores.switched   = r_sw;
                    n_ores.live_count = 5'(st_view.live);
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_en       <= 1'b0;
            r_cur      <= '0;
            r_idc      <= ID_W'(1);
            r_link_vld <= '0;
            r_id_vld   <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cur      <= n_cur;
            r_idc      <= n_idc;
            r_link_vld <= n_link_vld;
            r_id_vld   <= n_id_vld;
            r_ovalid   <= n_ovalid;
            if (i_cfg_we) begin
                r_en <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_item_valid) begin
            r_item <= i_item;
        end
        if (lk_re) begin
            r_laddr <= lk_raddr;
            r_lvld  <= r_link_vld[lk_raddr];
        end
        if (id_re) begin
            r_ivld <= r_id_vld[r_cur];
        end
        r_slot   <= n_slot;
        r_idv    <= n_idv;
        r_have   <= n_have;
        r_sw     <= n_sw;
        r_status <= n_status;
        r_p      <= n_p;
        r_k      <= n_k;
        r_lv     <= n_lv;
        r_ores   <= n_ores;
    end

    a_res_from_res_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_RES)
        else $error("result register loaded outside the result state");

    a_link_write_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lk_we |=> r_link_vld[$past(lk_waddr)])
        else $error("link entry written but not marked valid");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item_valid && o_item_ready) |=> (r_state != S_IDLE))
        else $error("accepted item did not start the sequencer");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (int'(o_res.live_count) <= SLOTS))
        else $error("live count exceeds slot count");

endmodule

/* rtl/core/rrtt_ram.sv */
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module rrtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/rrtt_stat.sv */
`timescale 1ns / 1ps
// Slot status file: per-slot state and ring membership flags, live counter,
// and the lowest free/dead slot search. Depends on rrtt_pkg.
module rrtt_stat (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrtt_pkg::t_st_cmd             i_cmd,
    input  logic [rrtt_pkg::SLOT_W-1:0]   i_cur_addr,
    input  logic [rrtt_pkg::SLOT_W-1:0]   i_sel_addr,
    input  logic [rrtt_pkg::SLOT_W-1:0]   i_walk_addr,
    output rrtt_pkg::t_st_view            o_view
);
    import rrtt_pkg::*;

    t_st               r_st [SLOTS];
    logic [SLOTS-1:0]  r_linked;
    logic [CNT_W-1:0]  r_live;
    logic [CNT_W-1:0]  n_live;
    logic              fu_ok;
    logic              fd_ok;
    logic [SLOT_W-1:0] fu_slot;
    logic [SLOT_W-1:0] fd_slot;
    logic              inc_a;
    logic              inc_b;
    logic              dec_a;
    logic              dec_b;

    always_comb begin
        fu_ok   = 1'b0;
        fd_ok   = 1'b0;
        fu_slot = '0;
        fd_slot = '0;
        for (int i = SLOTS - 1; i >= 1; i--) begin
            if (r_st[i] == ST_UNUSED) begin
                fu_ok   = 1'b1;
                fu_slot = SLOT_W'(i);
            end
            if (r_st[i] == ST_DEAD) begin
                fd_ok   = 1'b1;
                fd_slot = SLOT_W'(i);
            end
        end
    end

    assign inc_a  = i_cmd.a_we & is_live(i_cmd.a_val);
    assign dec_a  = i_cmd.a_we & is_live(r_st[i_cmd.a_addr]);
    assign inc_b  = i_cmd.b_we & is_live(i_cmd.b_val);
    assign dec_b  = i_cmd.b_we & is_live(r_st[i_cmd.b_addr]);
    assign n_live = r_live + CNT_W'(inc_a) + CNT_W'(inc_b) - CNT_W'(dec_a) - CNT_W'(dec_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_st[i] <= (i == 0) ? ST_RUNNING : ST_UNUSED;
            end
            r_linked <= SLOTS'(1);
            r_live   <= CNT_W'(1);
        end else begin
            if (i_cmd.a_we) begin
                r_st[i_cmd.a_addr] <= i_cmd.a_val;
            end
            if (i_cmd.b_we) begin
                r_st[i_cmd.b_addr] <= i_cmd.b_val;
            end
            if (i_cmd.lk_we) begin
                r_linked[i_cmd.lk_addr] <= i_cmd.lk_val;
            end
            r_live <= n_live;
        end
    end

    always_comb begin
        o_view.st_cur      = r_st[i_cur_addr];
        o_view.st_sel      = r_st[i_sel_addr];
        o_view.st_walk     = r_st[i_walk_addr];
        o_view.find_ok     = fu_ok | fd_ok;
        o_view.find_slot   = fu_ok ? fu_slot : fd_slot;
        o_view.find_dead   = ~fu_ok;
        o_view.find_linked = r_linked[fu_ok ? fu_slot : fd_slot];
        o_view.live        = r_live;
    end

endmodule
